@@ hdl/utf8_stream_validator_defines.svh @@
// Assertion macros used by the validator top level.
`ifndef UTF8_STREAM_VALIDATOR_DEFINES_SVH
`define UTF8_STREAM_VALIDATOR_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define U8V_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("u8v: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define U8V_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("u8v: next-cycle check failed");

`endif

@@ hdl/u8v_pkg.sv @@
// Shared types, byte class codes and code point checks for the UTF-8 validator.
package u8v_pkg;

    // Byte class codes
    localparam logic [2:0] KIND_ASCII = 3'd0;
    localparam logic [2:0] KIND_LEAD2 = 3'd1;
    localparam logic [2:0] KIND_LEAD3 = 3'd2;
    localparam logic [2:0] KIND_LEAD4 = 3'd3;
    localparam logic [2:0] KIND_CONT  = 3'd4;
    localparam logic [2:0] KIND_BAD   = 3'd5;

    // Code point limits
    localparam logic [20:0] CP_MIN2      = 21'h000080;
    localparam logic [20:0] CP_MIN3      = 21'h000800;
    localparam logic [20:0] CP_MIN4      = 21'h010000;
    localparam logic [20:0] CP_SURR_LO   = 21'h00D800;
    localparam logic [20:0] CP_SURR_HI   = 21'h00DFFF;
    localparam logic [20:0] CP_MAX       = 21'h10FFFF;

    // Sequence lengths
    localparam logic [2:0] SEQ_LEN2 = 3'd2;
    localparam logic [2:0] SEQ_LEN3 = 3'd3;
    localparam logic [2:0] SEQ_LEN4 = 3'd4;

    // Class queue geometry
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = 3;

    typedef struct packed {
        logic [2:0] kind;
        logic [5:0] payload;
        logic       last;
    } class_t;

    typedef struct packed {
        logic empty;
        logic full;
    } qstat_t;

    // Overlong, surrogate or out-of-range check on a finished code point
    function automatic logic cp_bad(input logic [2:0] len, input logic [20:0] cp);
        logic bad;
        bad = 1'b0;
        if (len == SEQ_LEN2 && cp < CP_MIN2)
        begin
            bad = 1'b1;
        end
        if (len == SEQ_LEN3 && cp < CP_MIN3)
        begin
            bad = 1'b1;
        end
        if (len == SEQ_LEN4 && cp < CP_MIN4)
        begin
            bad = 1'b1;
        end
        if (cp >= CP_SURR_LO && cp <= CP_SURR_HI)
        begin
            bad = 1'b1;
        end
        if (cp > CP_MAX)
        begin
            bad = 1'b1;
        end
        return bad;
    endfunction

endpackage

@@ hdl/utf8_stream_validator.sv @@
// UTF-8 stream validator top level: front classifier, class queue, back state engine.
// A pushed byte is stored in the class queue, then its result in the result queue.
// Throughput: one byte per cycle while the class queue is not full; one byte per cycle
// leaves it while a result slot is free; the back end's sequence update has no busy state.
// Reset (rst_n low, asynchronous) empties both queues and clears the sequence state.
`include "utf8_stream_validator_defines.svh"

module utf8_stream_validator
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    output logic       empty,
    input  logic       pop,
    output logic       string_done,
    output logic       still_valid
);

    u8v_pkg::qstat_t q_stat;
    u8v_pkg::class_t wr_item;
    u8v_pkg::class_t rd_item;
    logic            q_wr;
    logic            q_rd;

    u8v_front u_front
    (
        .push      (push),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .q_stat    (q_stat),
        .full      (full),
        .q_wr      (q_wr),
        .q_item    (wr_item)
    );

    u8v_queue u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_wr),
        .wr_item (wr_item),
        .rd_en   (q_rd),
        .rd_item (rd_item),
        .stat    (q_stat)
    );

    u8v_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_stat      (q_stat),
        .q_item      (rd_item),
        .q_rd        (q_rd),
        .pop         (pop),
        .empty       (empty),
        .string_done (string_done),
        .still_valid (still_valid)
    );

    // A transferred byte is waiting in the class queue on the next cycle
    `U8V_ASSERT_NEXT(a_push_lands, push && !full, !q_stat.empty)
    // A byte taken by the back end leaves a result to pop
    `U8V_ASSERT_NEXT(a_take_gives_result, q_rd, !empty)
    // The back end never reads an empty class queue
    `U8V_ASSERT_NOW(a_no_underrun, q_rd, !q_stat.empty)

endmodule

@@ hdl/u8v_front.sv @@
// Front end: accepts input bytes and classifies each one for the back end.
module u8v_front
(
    input  logic              push,
    input  logic [7:0]        data_byte,
    input  logic              last_byte,
    input  u8v_pkg::qstat_t   q_stat,
    output logic              full,
    output logic              q_wr,
    output u8v_pkg::class_t   q_item
);

    // Stall the producer while the class queue is full
    assign full = q_stat.full;
    assign q_wr = push && !q_stat.full;

    // Classify the byte and keep its value bits for lead and continuation bytes
    always_comb
    begin
        q_item.last    = last_byte;
        q_item.payload = 6'd0;
        q_item.kind    = u8v_pkg::KIND_BAD;
        case (data_byte) inside
            [8'h00:8'h7F]:
            begin
                q_item.kind = u8v_pkg::KIND_ASCII;
            end
            [8'h80:8'hBF]:
            begin
                q_item.kind    = u8v_pkg::KIND_CONT;
                q_item.payload = data_byte[5:0];
            end
            [8'hC2:8'hDF]:
            begin
                q_item.kind    = u8v_pkg::KIND_LEAD2;
                q_item.payload = {1'b0, data_byte[4:0]};
            end
            [8'hE0:8'hEF]:
            begin
                q_item.kind    = u8v_pkg::KIND_LEAD3;
                q_item.payload = {2'b00, data_byte[3:0]};
            end
            [8'hF0:8'hF4]:
            begin
                q_item.kind    = u8v_pkg::KIND_LEAD4;
                q_item.payload = {3'b000, data_byte[2:0]};
            end
            default:
            begin
                q_item.kind = u8v_pkg::KIND_BAD;
            end
        endcase
    end

endmodule

@@ hdl/u8v_queue.sv @@
// Small queue of classified bytes between the front end and the back end.
module u8v_queue
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  u8v_pkg::class_t   wr_item,
    input  logic              rd_en,
    output u8v_pkg::class_t   rd_item,
    output u8v_pkg::qstat_t   stat
);

    u8v_pkg::class_t                  slot_reg [u8v_pkg::Q_DEPTH];
    logic [u8v_pkg::Q_PTR_W-1:0]      wr_ptr_reg;
    logic [u8v_pkg::Q_PTR_W-1:0]      wr_ptr_next;
    logic [u8v_pkg::Q_PTR_W-1:0]      rd_ptr_reg;
    logic [u8v_pkg::Q_PTR_W-1:0]      rd_ptr_next;
    logic [u8v_pkg::Q_CNT_W-1:0]      cnt_reg;
    logic [u8v_pkg::Q_CNT_W-1:0]      cnt_next;

    assign stat.empty = (cnt_reg == '0);
    assign stat.full  = (cnt_reg == u8v_pkg::Q_CNT_W'(u8v_pkg::Q_DEPTH));
    assign rd_item    = slot_reg[rd_ptr_reg];

    // Advance pointers and count on each transfer
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + u8v_pkg::Q_PTR_W'(wr_en);
        rd_ptr_next = rd_ptr_reg + u8v_pkg::Q_PTR_W'(rd_en);
        cnt_next    = cnt_reg;
        if (wr_en && !rd_en)
        begin
            cnt_next = cnt_reg + u8v_pkg::Q_CNT_W'(1);
        end
        else if (!wr_en && rd_en)
        begin
            cnt_next = cnt_reg - u8v_pkg::Q_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Store the incoming item
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

@@ hdl/u8v_back.sv @@
// Back end: runs the sequence state per byte and queues one result per byte.
module u8v_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  u8v_pkg::qstat_t   q_stat,
    input  u8v_pkg::class_t   q_item,
    output logic              q_rd,
    input  logic              pop,
    output logic              empty,
    output logic              string_done,
    output logic              still_valid
);

    // Sequence state
    logic [1:0]  pending_reg;
    logic [1:0]  pending_next;
    logic [2:0]  seq_len_reg;
    logic [2:0]  seq_len_next;
    logic [20:0] cp_reg;
    logic [20:0] cp_next;
    logic        err_reg;
    logic        err_next;
    logic        ok;
    logic [20:0] cp_shift;
    logic [1:0]  pending_dec;

    // Result queue, two entries
    logic        res_done_reg [2];
    logic        res_ok_reg   [2];
    logic        res_wr_ptr_reg;
    logic        res_rd_ptr_reg;
    logic [1:0]  res_cnt_reg;
    logic [1:0]  res_cnt_next;
    logic        res_pop;

    // Take a byte whenever one waits and a result slot is free
    assign q_rd    = !q_stat.empty && (res_cnt_reg != 2'd2);
    assign res_pop = pop && !empty;

    assign cp_shift    = {cp_reg[14:0], q_item.payload};
    assign pending_dec = pending_reg - 2'd1;

    // Next sequence state for the byte at the queue head
    always_comb
    begin
        pending_next = pending_reg;
        seq_len_next = seq_len_reg;
        cp_next      = cp_reg;
        err_next     = err_reg;
        if (!err_reg)
        begin
            if (pending_reg != 2'd0)
            begin
                if (q_item.kind != u8v_pkg::KIND_CONT)
                begin
                    err_next     = 1'b1;
                    pending_next = 2'd0;
                end
                else
                begin
                    cp_next      = cp_shift;
                    pending_next = pending_dec;
                    if (pending_dec == 2'd0)
                    begin
                        err_next     = u8v_pkg::cp_bad(seq_len_reg, cp_shift);
                        seq_len_next = 3'd0;
                        cp_next      = 21'd0;
                    end
                end
            end
            else
            begin
                case (q_item.kind)
                    u8v_pkg::KIND_ASCII:
                    begin
                        err_next = 1'b0;
                    end
                    u8v_pkg::KIND_LEAD2:
                    begin
                        seq_len_next = u8v_pkg::SEQ_LEN2;
                        cp_next      = {15'd0, q_item.payload};
                        pending_next = 2'd1;
                    end
                    u8v_pkg::KIND_LEAD3:
                    begin
                        seq_len_next = u8v_pkg::SEQ_LEN3;
                        cp_next      = {15'd0, q_item.payload};
                        pending_next = 2'd2;
                    end
                    u8v_pkg::KIND_LEAD4:
                    begin
                        seq_len_next = u8v_pkg::SEQ_LEN4;
                        cp_next      = {15'd0, q_item.payload};
                        pending_next = 2'd3;
                    end
                    default:
                    begin
                        err_next = 1'b1;
                    end
                endcase
            end
        end
        // Verdict, then clear everything at string end
        ok = !err_next;
        if (q_item.last)
        begin
            if (pending_next != 2'd0)
            begin
                ok = 1'b0;
            end
            pending_next = 2'd0;
            seq_len_next = 3'd0;
            cp_next      = 21'd0;
            err_next     = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 2'd0;
            seq_len_reg <= 3'd0;
            cp_reg      <= 21'd0;
            err_reg     <= 1'b0;
        end
        else if (q_rd)
        begin
            pending_reg <= pending_next;
            seq_len_reg <= seq_len_next;
            cp_reg      <= cp_next;
            err_reg     <= err_next;
        end
    end

    // Track result queue occupancy
    always_comb
    begin
        res_cnt_next = res_cnt_reg;
        if (q_rd && !res_pop)
        begin
            res_cnt_next = res_cnt_reg + 2'd1;
        end
        else if (!q_rd && res_pop)
        begin
            res_cnt_next = res_cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_wr_ptr_reg <= 1'b0;
            res_rd_ptr_reg <= 1'b0;
            res_cnt_reg    <= 2'd0;
        end
        else
        begin
            res_cnt_reg <= res_cnt_next;
            if (q_rd)
            begin
                res_wr_ptr_reg <= !res_wr_ptr_reg;
            end
            if (res_pop)
            begin
                res_rd_ptr_reg <= !res_rd_ptr_reg;
            end
        end
    end

    // Hold each result until it is transferred
    always_ff @(posedge clk)
    begin
        if (q_rd)
        begin
            res_done_reg[res_wr_ptr_reg] <= q_item.last;
            res_ok_reg[res_wr_ptr_reg]   <= ok;
        end
    end

    assign empty       = (res_cnt_reg == 2'd0);
    assign string_done = res_done_reg[res_rd_ptr_reg];
    assign still_valid = res_ok_reg[res_rd_ptr_reg];

endmodule

@@ verif/utf8_stream_validator_test.sv @@
// Self-checking testbench for the UTF-8 stream validator: directed strings, then random text.
`timescale 1ns / 100ps

module utf8_stream_validator_test;

    // Lead byte ranges
    localparam logic [7:0] LEAD2_LO = 8'hC2;
    localparam logic [7:0] LEAD2_HI = 8'hDF;
    localparam logic [7:0] LEAD3_LO = 8'hE0;
    localparam logic [7:0] LEAD3_HI = 8'hEF;
    localparam logic [7:0] LEAD4_LO = 8'hF0;
    localparam logic [7:0] LEAD4_HI = 8'hF4;

    // Code point limits
    localparam logic [20:0] MIN_TWO   = 21'h000080;
    localparam logic [20:0] MIN_THREE = 21'h000800;
    localparam logic [20:0] MIN_FOUR  = 21'h010000;
    localparam logic [20:0] SURR_LO   = 21'h00D800;
    localparam logic [20:0] SURR_HI   = 21'h00DFFF;
    localparam logic [20:0] TOP_CP    = 21'h10FFFF;

    // Directed row kinds
    localparam logic ROW_PRED  = 1'b0;
    localparam logic ROW_TYPED = 1'b1;

    localparam int RANDOM_BYTES = 900;
    localparam int STALL_LIMIT  = 2000;
    localparam int TAIL_CYCLES  = 40;
    localparam int DIRECTED_ROWS = 24;

    typedef struct packed {
        logic done;
        logic valid;
    } verdict_t;

    typedef struct packed {
        logic [7:0] byte_val;
        logic       is_last;
        logic       kind;
        verdict_t   verdict;
    } row_t;

    logic       clk;
    logic       rst_n     = 1'b0;
    logic       push      = 1'b0;
    logic       pop       = 1'b0;
    logic [7:0] data_byte = 8'h00;
    logic       last_byte = 1'b0;
    logic       full;
    logic       empty;
    logic       string_done;
    logic       still_valid;

    // Predictor state
    logic [1:0]  cont_left = 2'd0;
    logic [2:0]  seq_len   = 3'd0;
    logic [20:0] cp_acc    = 21'd0;
    logic        err_flag  = 1'b0;

    verdict_t   expected_verdicts[$];
    logic [7:0] text_bytes[$];
    row_t       directed_rows [0:DIRECTED_ROWS-1];
    int         mismatch_count = 0;
    int         result_count   = 0;
    int         stall_count    = 0;
    int         send_calm      = 0;
    int         recv_calm      = 0;

    utf8_stream_validator u_dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .data_byte   (data_byte),
        .last_byte   (last_byte),
        .empty       (empty),
        .pop         (pop),
        .string_done (string_done),
        .still_valid (still_valid)
    );

    // Free-running clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Print one mismatch line and count it
    task automatic report(input string msg);
        mismatch_count++;
        $display("[%0t] mismatch %0d: %s", $realtime, mismatch_count, msg);
    endtask

    // Append one byte to the pending text
    task automatic add_text_byte(input logic [7:0] b);
        text_bytes = {text_bytes, b};
    endtask

    // Reject overlong forms, surrogates and values past the top code point
    function automatic logic cp_rejected(input logic [2:0] len, input logic [20:0] cp);
        logic bad;
        bad = 1'b0;
        if (len == 3'd2 && cp < MIN_TWO)
        begin
            bad = 1'b1;
        end
        if (len == 3'd3 && cp < MIN_THREE)
        begin
            bad = 1'b1;
        end
        if (len == 3'd4 && cp < MIN_FOUR)
        begin
            bad = 1'b1;
        end
        if (cp >= SURR_LO && cp <= SURR_HI)
        begin
            bad = 1'b1;
        end
        if (cp > TOP_CP)
        begin
            bad = 1'b1;
        end
        return bad;
    endfunction

    // Advance the decoder state by one byte and return the verdict it yields
    function automatic verdict_t track_byte(input logic [7:0] b, input logic last);
        verdict_t v;
        logic     ok;
        if (!err_flag)
        begin
            if (cont_left != 2'd0)
            begin
                if (b[7:6] != 2'b10)
                begin
                    err_flag  = 1'b1;
                    cont_left = 2'd0;
                end
                else
                begin
                    cp_acc    = {cp_acc[14:0], b[5:0]};
                    cont_left = cont_left - 2'd1;
                    if (cont_left == 2'd0)
                    begin
                        if (cp_rejected(seq_len, cp_acc))
                        begin
                            err_flag = 1'b1;
                        end
                        seq_len = 3'd0;
                        cp_acc  = 21'd0;
                    end
                end
            end
            else if (b[7])
            begin
                if (b >= LEAD2_LO && b <= LEAD2_HI)
                begin
                    seq_len   = 3'd2;
                    cp_acc    = {16'd0, b[4:0]};
                    cont_left = 2'd1;
                end
                else if (b >= LEAD3_LO && b <= LEAD3_HI)
                begin
                    seq_len   = 3'd3;
                    cp_acc    = {17'd0, b[3:0]};
                    cont_left = 2'd2;
                end
                else if (b >= LEAD4_LO && b <= LEAD4_HI)
                begin
                    seq_len   = 3'd4;
                    cp_acc    = {18'd0, b[2:0]};
                    cont_left = 2'd3;
                end
                else
                begin
                    err_flag = 1'b1;
                end
            end
        end
        ok = !err_flag;
        if (last)
        begin
            if (cont_left != 2'd0)
            begin
                ok = 1'b0;
            end
            cont_left = 2'd0;
            seq_len   = 3'd0;
            cp_acc    = 21'd0;
            err_flag  = 1'b0;
        end
        v.done  = last;
        v.valid = ok;
        return v;
    endfunction

    // Draw a wait, with occasional runs of back-to-back transfers
    function automatic int draw_wait(inout int calm);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0)
        begin
            calm = $urandom_range(10, 40);
        end
        return $urandom_range(0, 16);
    endfunction

    // Transfer one byte in and queue its expected verdict
    task automatic send_byte(input logic [7:0] b, input logic last, input row_t row);
        int       gap;
        verdict_t v;
        gap = draw_wait(send_calm);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push      <= 1'b1;
        data_byte <= b;
        last_byte <= last;
        @(posedge clk);
        while (full)
        begin
            @(posedge clk);
        end
        v = track_byte(b, last);
        if (row.kind == ROW_TYPED)
        begin
            v = row.verdict;
        end
        expected_verdicts = {expected_verdicts, v};
    endtask

    // Append one character of random text: mostly well formed, some broken, some noise
    task automatic add_char();
        int          mode;
        int          len;
        int          conts;
        logic [20:0] cp;
        logic [7:0]  lead;
        mode = $urandom_range(0, 99);
        if (mode < 60)
        begin
            len = $urandom_range(1, 4);
            case (len)
                1: cp = 21'($urandom_range(0, 8'h7F));
                2: cp = 21'($urandom_range(12'h080, 12'h7FF));
                3:
                begin
                    cp = 21'($urandom_range(16'h0800, 16'hFFFF));
                    if (cp >= SURR_LO && cp <= SURR_HI)
                    begin
                        cp = cp + 21'h000800;
                    end
                end
                default: cp = 21'($urandom_range(21'h010000, 21'h10FFFF));
            endcase
            case (len)
                1: add_text_byte({1'b0, cp[6:0]});
                2:
                begin
                    add_text_byte({3'b110, cp[10:6]});
                    add_text_byte({2'b10, cp[5:0]});
                end
                3:
                begin
                    add_text_byte({4'b1110, cp[15:12]});
                    add_text_byte({2'b10, cp[11:6]});
                    add_text_byte({2'b10, cp[5:0]});
                end
                default:
                begin
                    add_text_byte({5'b11110, cp[20:18]});
                    add_text_byte({2'b10, cp[17:12]});
                    add_text_byte({2'b10, cp[11:6]});
                    add_text_byte({2'b10, cp[5:0]});
                end
            endcase
        end
        else if (mode < 80)
        begin
            // Any lead with random tails: reaches overlongs, surrogates and out-of-range
            lead = 8'($urandom_range(8'hC0, 8'hF7));
            if (lead >= LEAD4_LO)
            begin
                conts = 3;
            end
            else if (lead >= LEAD3_LO)
            begin
                conts = 2;
            end
            else
            begin
                conts = 1;
            end
            if ($urandom_range(0, 3) == 0)
            begin
                conts = $urandom_range(0, conts);
            end
            add_text_byte(lead);
            repeat (conts) add_text_byte({2'b10, 6'($urandom_range(0, 63))});
        end
        else
        begin
            add_text_byte(8'($urandom_range(0, 255)));
        end
    endtask

    // Stall watchdog: end the run when no transfer happens for too long
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty))
        begin
            stall_count <= 0;
        end
        else if (stall_count >= STALL_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
        else
        begin
            stall_count <= stall_count + 1;
        end
    end

    // Result side: pop with random stalls and check each transfer
    initial
    begin : result_side
        int       gap;
        verdict_t want;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            gap = draw_wait(recv_calm);
            if (gap > 0)
            begin
                pop <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            pop <= 1'b1;
            @(posedge clk);
            while (empty)
            begin
                @(posedge clk);
            end
            result_count++;
            if (expected_verdicts.size() == 0)
            begin
                report($sformatf("result %0d arrived with nothing expected", result_count));
            end
            else
            begin
                want = expected_verdicts.pop_front();
                if (string_done !== want.done)
                begin
                    report($sformatf("result %0d string_done got %b want %b",
                                     result_count, string_done, want.done));
                end
                if (still_valid !== want.valid)
                begin
                    report($sformatf("result %0d still_valid got %b want %b",
                                     result_count, still_valid, want.valid));
                end
            end
        end
    end

    // Stimulus and final verdict
    initial
    begin : input_side
        int   random_sent;
        int   chars;
        int   i;
        row_t noise_row;
        directed_rows = '{
            '{8'h00, 1'b1, ROW_TYPED, '{1'b1, 1'b1}},
            '{8'h7F, 1'b1, ROW_TYPED, '{1'b1, 1'b1}},
            // bad lead alone
            '{8'hFF, 1'b1, ROW_TYPED, '{1'b1, 1'b0}},
            // bad lead, then a stray continuation ignored under the sticky error
            '{8'hC0, 1'b0, ROW_TYPED, '{1'b0, 1'b0}},
            '{8'h80, 1'b1, ROW_TYPED, '{1'b1, 1'b0}},
            // highest two-byte form
            '{8'hDF, 1'b0, ROW_PRED,  '{1'b0, 1'b0}},
            '{8'hBF, 1'b1, ROW_PRED,  '{1'b0, 1'b0}},
            // overlong three-byte form
            '{8'hE0, 1'b0, ROW_PRED,  '{1'b0, 1'b0}},
            '{8'h80, 1'b0, ROW_PRED,  '{1'b0, 1'b0}},
            '{8'h80, 1'b1, ROW_PRED,  '{1'b0, 1'b0}},
            // surrogate
            '{8'hED, 1'b0, ROW_PRED,  '{1'b0, 1'b0}},
            '{8'hA0, 1'b0, ROW_PRED,  '{1'b0, 1'b0}},
            '{8'h80, 1'b1, ROW_PRED,  '{1'b0, 1'b0}},
            // top code point
            '{8'hF4, 1'b0, ROW_PRED,  '{1'b0, 1'b0}},
            '{8'h8F, 1'b0, ROW_PRED,  '{1'b0, 1'b0}},
            '{8'hBF, 1'b0, ROW_PRED,  '{1'b0, 1'b0}},
            '{8'hBF, 1'b1, ROW_PRED,  '{1'b0, 1'b0}},
            // one past the top code point
            '{8'hF4, 1'b0, ROW_PRED,  '{1'b0, 1'b0}},
            '{8'h90, 1'b0, ROW_PRED,  '{1'b0, 1'b0}},
            '{8'h80, 1'b0, ROW_PRED,  '{1'b0, 1'b0}},
            '{8'h80, 1'b1, ROW_PRED,  '{1'b0, 1'b0}},
            // sequence still open at string end
            '{8'hE1, 1'b1, ROW_TYPED, '{1'b1, 1'b0}},
            // missing continuation
            '{8'hC2, 1'b0, ROW_PRED,  '{1'b0, 1'b0}},
            '{8'h41, 1'b1, ROW_PRED,  '{1'b0, 1'b0}}
        };
        noise_row = '{8'h00, 1'b0, ROW_PRED, '{1'b0, 1'b0}};

        // Hold reset, then release at an edge
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table
        for (i = 0; i < DIRECTED_ROWS; i++)
        begin
            send_byte(directed_rows[i].byte_val, directed_rows[i].is_last, directed_rows[i]);
        end

        // Random strings of 1 to 10 characters
        random_sent = 0;
        while (random_sent < RANDOM_BYTES)
        begin
            chars = $urandom_range(1, 10);
            repeat (chars) add_char();
            while (text_bytes.size() > 0)
            begin
                send_byte(text_bytes[0], text_bytes.size() == 1, noise_row);
                void'(text_bytes.pop_front());
                random_sent++;
            end
        end
        push <= 1'b0;

        // Drain, then watch for stray results
        while (expected_verdicts.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/u8v_pkg.sv
hdl/u8v_front.sv
hdl/u8v_queue.sv
hdl/u8v_back.sv
hdl/utf8_stream_validator.sv
verif/utf8_stream_validator_test.sv
